>>> rtl/core/nsg_pkg.sv
package nsg_pkg;

    // Note memory geometry and fixed point format
    localparam int NOTE_DEPTH    = 256;
    localparam int FRACTION_BITS = 8;
    localparam int ADDR_W        = $clog2(NOTE_DEPTH);

    // Field widths
    localparam int ACT_W   = 2;
    localparam int PITCH_W = 7;
    localparam int DELAY_W = 16;
    localparam int LOUD_W  = 7;
    localparam int GATE_W  = 8;
    localparam int VOICE_W = 8;
    localparam int LEN_W   = 9;
    localparam int STEP_W  = 14;
    localparam int EV_W    = 3;

    // Gate is given in 256ths of the delay
    localparam int GATE_SHIFT = 8;

    // Signed tick counters: whole delay, fraction, sign and headroom
    localparam int TIME_W = DELAY_W + FRACTION_BITS + 2;

    // Result limit of one tick
    localparam int MAX_RES = 64;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [PITCH_W-1:0] REST_PITCH = 7'd127;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_TICK  = 2'd3
    } nsg_action_t;

    typedef enum logic [EV_W-1:0] {
        EV_ON      = 3'd0,
        EV_RELEASE = 3'd1,
        EV_CUT     = 3'd2,
        EV_TAKEN   = 3'd3,
        EV_REFUSED = 3'd4
    } nsg_event_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } nsg_alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_STOP,
        S_TICK,
        S_REL_CHK,
        S_NEXT_SUB,
        S_CHECK,
        S_READ,
        S_REST,
        S_MUL,
        S_GATE,
        S_FINISH
    } nsg_state_t;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [DELAY_W-1:0] delay;
        logic [LOUD_W-1:0]  loud;
        logic [GATE_W-1:0]  gate;
    } nsg_entry_t;

    typedef struct packed {
        nsg_event_t         ev;
        logic [PITCH_W-1:0] pitch;
        logic [LOUD_W-1:0]  loud;
        logic [VOICE_W-1:0] voice;
    } nsg_result_t;

    typedef struct packed {
        logic        push;
        logic        finish;
        nsg_result_t res;
    } nsg_push_t;

    function automatic logic is_nonpos(input logic signed [TIME_W-1:0] x);
        return x[TIME_W-1] || (x == '0);
    endfunction

endpackage

>>> rtl/core/nsg_note_mem.sv
module nsg_note_mem (
    input  logic                     clk,
    input  logic                     we,
    input  logic [nsg_pkg::ADDR_W-1:0] waddr,
    input  nsg_pkg::nsg_entry_t      wdata,
    input  logic                     re,
    input  logic [nsg_pkg::ADDR_W-1:0] raddr,
    output nsg_pkg::nsg_entry_t      rdata
);
    import nsg_pkg::*;

    nsg_entry_t mem [NOTE_DEPTH];
    nsg_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/nsg_alu.sv
module nsg_alu (
    input  nsg_pkg::nsg_alu_op_t              op,
    input  logic signed [nsg_pkg::TIME_W-1:0] a,
    input  logic signed [nsg_pkg::TIME_W-1:0] b,
    output logic signed [nsg_pkg::TIME_W-1:0] res
);
    import nsg_pkg::*;

    logic [DELAY_W+GATE_W-1:0] prod;

    // Gate tail product: delay times gate, scaled back by the gate fraction
    assign prod = (DELAY_W+GATE_W)'(a[DELAY_W-1:0]) * (DELAY_W+GATE_W)'(b[GATE_W-1:0]);

    always_comb
    begin
        unique case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
            ALU_MUL: res = TIME_W'(prod >> GATE_SHIFT);
            default: res = a - b;
        endcase
    end

endmodule

>>> rtl/core/nsg_out_stage.sv
module nsg_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nsg_pkg::nsg_push_t        req,
    output logic                      ok,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [nsg_pkg::EV_W-1:0]    event_res,
    output logic [nsg_pkg::PITCH_W-1:0] note_pitch,
    output logic [nsg_pkg::LOUD_W-1:0]  note_loudness,
    output logic [nsg_pkg::VOICE_W-1:0] note_voice,
    output logic                      last
);
    import nsg_pkg::*;

    // One result waits in the pending slot until the next one (or the end of
    // the transaction) tells whether it is the last.
    logic        pend_valid_reg;
    nsg_result_t pend_reg;
    logic        out_valid_reg;
    nsg_result_t out_reg;
    logic        out_last_reg;
    logic        slot_free;
    logic        load_out;

    assign slot_free = !out_valid_reg || !out_stall;
    assign ok        = !pend_valid_reg || slot_free;
    assign load_out  = (req.push || req.finish) && pend_valid_reg && ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.push && ok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (req.finish && ok)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push && ok)
        begin
            pend_reg <= req.res;
        end
        if (load_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= req.finish;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.ev;
    assign note_pitch    = out_reg.pitch;
    assign note_loudness = out_reg.loud;
    assign note_voice    = out_reg.voice;
    assign last          = out_last_reg;

`ifndef ASSERT_OFF
    a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (req.finish && ok) |=> !pend_valid_reg)
        else $error("pending result survived the end of a transaction");

    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pend_valid_reg))
        else $error("output loaded without a pending result");
`endif

endmodule

>>> rtl/core/note_sequencer_with_gate_time.sv
// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------------------
// in       in_valid / in_stall  action entry_addr pitch delay_ticks loudness gate
//                               song_first song_length step_size voice
//                               current_voice
// out      out_valid/out_stall  event_res note_pitch note_loudness note_voice last
//
// A load is absorbed at once. Otherwise in_stall stays high until the sequencer has
// finished a stop, start or tick, including every rest and note that a tick drains; the
// shared add/subtract/multiply unit and the one registered read port of the note memory
// set the pace, and a stalled output holds the sequencer.
// Reset clears all song state; the note memory holds garbage until loaded.
module note_sequencer_with_gate_time (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nsg_pkg::ACT_W-1:0]     action,
    input  logic [7:0]                    entry_addr,
    input  logic [nsg_pkg::PITCH_W-1:0]   pitch,
    input  logic [nsg_pkg::DELAY_W-1:0]   delay_ticks,
    input  logic [nsg_pkg::LOUD_W-1:0]    loudness,
    input  logic [nsg_pkg::GATE_W-1:0]    gate,
    input  logic [7:0]                    song_first,
    input  logic [nsg_pkg::LEN_W-1:0]     song_length,
    input  logic [nsg_pkg::STEP_W-1:0]    step_size,
    input  logic [nsg_pkg::VOICE_W-1:0]   voice,
    input  logic [nsg_pkg::VOICE_W-1:0]   current_voice,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nsg_pkg::EV_W-1:0]      event_res,
    output logic [nsg_pkg::PITCH_W-1:0]   note_pitch,
    output logic [nsg_pkg::LOUD_W-1:0]    note_loudness,
    output logic [nsg_pkg::VOICE_W-1:0]   note_voice,
    output logic                          last
);
    import nsg_pkg::*;

    nsg_state_t state_reg, state_next;

    // Song state
    logic [ADDR_W-1:0]         base_reg, base_next;
    logic [LEN_W-1:0]          count_reg, count_next;
    logic [LEN_W-1:0]          idx_reg, idx_next;
    logic signed [TIME_W-1:0]  ttn_reg, ttn_next;
    logic signed [TIME_W-1:0]  ttr_reg, ttr_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [VOICE_W-1:0]        lvoice_reg, lvoice_next;
    logic                      playing_reg, playing_next;
    logic                      held_reg, held_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    // Copy of the accepted transaction
    logic [7:0]                item_first_reg;
    logic [LEN_W-1:0]          item_len_reg;
    logic [STEP_W-1:0]         item_step_reg;
    logic [VOICE_W-1:0]        item_voice_reg;
    logic [VOICE_W-1:0]        item_cur_reg;

    logic                      accept;
    logic                      mem_we;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;
    nsg_entry_t                mem_wdata;
    nsg_entry_t                mem_rdata;

    nsg_alu_op_t               alu_op;
    logic signed [TIME_W-1:0]  alu_a;
    logic signed [TIME_W-1:0]  alu_b;
    logic signed [TIME_W-1:0]  alu_res;

    nsg_push_t                 push_req;
    logic                      out_ok;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Loads go straight into the note memory on acceptance
    assign mem_we          = accept && (nsg_action_t'(action) == ACT_LOAD);
    assign mem_wdata.pitch = pitch;
    assign mem_wdata.delay = delay_ticks;
    assign mem_wdata.loud  = loudness;
    assign mem_wdata.gate  = gate;

    // Song entry k lives at base + k, wrapping over the memory depth
    assign mem_raddr = ADDR_W'(base_reg + ADDR_W'(idx_reg));

    nsg_note_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(entry_addr)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nsg_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    nsg_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (push_req),
        .ok            (out_ok),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .note_pitch    (note_pitch),
        .note_loudness (note_loudness),
        .note_voice    (note_voice),
        .last          (last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            base_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            ttn_reg     <= '0;
            ttr_reg     <= '0;
            step_reg    <= '0;
            lvoice_reg  <= '0;
            playing_reg <= 1'b0;
            held_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            ttn_reg     <= ttn_next;
            ttr_reg     <= ttr_next;
            step_reg    <= step_next;
            lvoice_reg  <= lvoice_next;
            playing_reg <= playing_next;
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_first_reg <= song_first;
            item_len_reg   <= song_length;
            item_step_reg  <= step_size;
            item_voice_reg <= voice;
            item_cur_reg   <= current_voice;
        end
    end

    // Sequencer: every step on the tick counters goes through the shared unit, one per
    // cycle; any state that emits a result waits for the output stage.
    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        ttn_next     = ttn_reg;
        ttr_next     = ttr_reg;
        step_next    = step_reg;
        lvoice_next  = lvoice_reg;
        playing_next = playing_reg;
        held_next    = held_reg;
        cnt_next     = cnt_reg;
        alu_op       = ALU_SUB;
        alu_a        = ttn_reg;
        alu_b        = TIME_W'(step_reg);
        mem_re       = 1'b0;
        push_req     = '0;
        push_req.res.ev = EV_CUT;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (nsg_action_t'(action))
                        ACT_LOAD:  state_next = S_IDLE;
                        ACT_START: state_next = S_START;
                        ACT_STOP:  state_next = S_STOP;
                        ACT_TICK:  state_next = S_TICK;
                    endcase
                end
            end

            S_START:
            begin
                push_req.push = 1'b1;
                if (item_voice_reg == '0 || item_len_reg == '0)
                begin
                    // Refuse and leave the song untouched
                    push_req.res.ev = EV_REFUSED;
                    if (out_ok)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (playing_reg)
                begin
                    // Cut the sounding song first, then come back here
                    push_req.res.ev = EV_CUT;
                    if (out_ok)
                    begin
                        playing_next = 1'b0;
                        held_next    = 1'b0;
                    end
                end
                else
                begin
                    push_req.res.ev = EV_TAKEN;
                    if (out_ok)
                    begin
                        base_next    = ADDR_W'(item_first_reg);
                        count_next   = item_len_reg;
                        idx_next     = '0;
                        ttn_next     = '0;
                        ttr_next     = '0;
                        step_next    = item_step_reg;
                        lvoice_next  = item_voice_reg;
                        playing_next = 1'b1;
                        held_next    = 1'b0;
                        state_next   = S_FINISH;
                    end
                end
            end

            S_STOP:
            begin
                if (playing_reg)
                begin
                    push_req.push   = 1'b1;
                    push_req.res.ev = EV_CUT;
                    if (out_ok)
                    begin
                        playing_next = 1'b0;
                        held_next    = 1'b0;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    held_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end

            S_TICK:
            begin
                cnt_next = '0;
                if (!playing_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (item_cur_reg != lvoice_reg)
                begin
                    push_req.push   = 1'b1;
                    push_req.res.ev = EV_CUT;
                    if (out_ok)
                    begin
                        playing_next = 1'b0;
                        held_next    = 1'b0;
                        state_next   = S_FINISH;
                    end
                end
                else if (held_reg)
                begin
                    // Advance the gate counter
                    alu_a      = ttr_reg;
                    ttr_next   = alu_res;
                    state_next = S_REL_CHK;
                end
                else
                begin
                    state_next = S_NEXT_SUB;
                end
            end

            S_REL_CHK:
            begin
                if (is_nonpos(ttr_reg))
                begin
                    push_req.push   = 1'b1;
                    push_req.res.ev = EV_RELEASE;
                    if (out_ok)
                    begin
                        held_next  = 1'b0;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_NEXT_SUB;
                    end
                end
                else
                begin
                    state_next = S_NEXT_SUB;
                end
            end

            S_NEXT_SUB:
            begin
                alu_a      = ttn_reg;
                ttn_next   = alu_res;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (is_nonpos(ttn_reg) && cnt_reg < CNT_W'(MAX_RES))
                begin
                    if (idx_reg >= count_reg)
                    begin
                        // Song ran out
                        push_req.push   = 1'b1;
                        push_req.res.ev = EV_CUT;
                        if (out_ok)
                        begin
                            playing_next = 1'b0;
                            held_next    = 1'b0;
                            state_next   = S_FINISH;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_READ:
            begin
                alu_op     = ALU_ADD;
                alu_a      = ttn_reg;
                alu_b      = TIME_W'({mem_rdata.delay, {FRACTION_BITS{1'b0}}});
                ttn_next   = alu_res;
                idx_next   = idx_reg + 1'b1;
                state_next = (mem_rdata.pitch == REST_PITCH) ? S_REST : S_MUL;
            end

            S_REST:
            begin
                push_req.push   = 1'b1;
                push_req.res.ev = EV_RELEASE;
                if (out_ok)
                begin
                    held_next  = 1'b0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_MUL:
            begin
                // Silent tail of the delay, parked in the gate counter
                alu_op     = ALU_MUL;
                alu_a      = TIME_W'(mem_rdata.delay);
                alu_b      = TIME_W'(mem_rdata.gate);
                ttr_next   = alu_res;
                state_next = S_GATE;
            end

            S_GATE:
            begin
                alu_op             = ALU_SUB;
                alu_a              = TIME_W'({mem_rdata.delay, {FRACTION_BITS{1'b0}}});
                alu_b              = TIME_W'({ttr_reg[DELAY_W-1:0], {FRACTION_BITS{1'b0}}});
                push_req.push      = 1'b1;
                push_req.res.ev    = EV_ON;
                push_req.res.pitch = mem_rdata.pitch;
                push_req.res.loud  = mem_rdata.loud;
                push_req.res.voice = lvoice_reg;
                if (out_ok)
                begin
                    ttr_next   = alu_res;
                    held_next  = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_FINISH:
            begin
                // Flush the pending result marked as last
                push_req.finish = 1'b1;
                if (out_ok)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_held_needs_song: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> playing_reg)
        else $error("note held without a playing song");

    a_index_in_song: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (idx_reg <= count_reg))
        else $error("song index ran past the song length");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RES))
        else $error("tick exceeded its result limit");
`endif

endmodule

>>> tb/nsg_tb_pkg.sv
package nsg_tb_pkg;

    import nsg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // One input transaction, every field as the block sees it
    typedef struct packed {
        nsg_action_t         act;
        logic [7:0]          addr;
        logic [PITCH_W-1:0]  pitch;
        logic [DELAY_W-1:0]  delay;
        logic [LOUD_W-1:0]   loud;
        logic [GATE_W-1:0]   gate;
        logic [7:0]          first;
        logic [LEN_W-1:0]    len;
        logic [STEP_W-1:0]   step_size;
        logic [VOICE_W-1:0]  voice;
        logic [VOICE_W-1:0]  cur_voice;
    } seq_txn_t;

    // One result transaction
    typedef struct packed {
        nsg_event_t          ev;
        logic [PITCH_W-1:0]  pitch;
        logic [LOUD_W-1:0]   loud;
        logic [VOICE_W-1:0]  voice;
        logic                last;
    } seq_event_t;

    class sequencer_scoreboard;

        nsg_entry_t          notes [NOTE_DEPTH];
        bit                  loaded [NOTE_DEPTH];
        int                  song_base;
        int                  song_count;
        int                  next_idx;
        int                  to_next;
        int                  to_release;
        int                  tick_step;
        logic [VOICE_W-1:0]  held_voice;
        bit                  playing;
        bit                  sounding;
        seq_event_t          burst [$];
        seq_event_t          expected_events [$];
        int                  mismatches;

        function new();
            song_base  = 0;
            song_count = 0;
            next_idx   = 0;
            to_next    = 0;
            to_release = 0;
            tick_step  = 0;
            held_voice = '0;
            playing    = 1'b0;
            sounding   = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function int to_fix(int ticks);
            return ticks <<< FRACTION_BITS;
        endfunction

        function int song_addr(int k);
            return (song_base + k) % NOTE_DEPTH;
        endfunction

        function void emit(nsg_event_t ev, logic [PITCH_W-1:0] p, logic [LOUD_W-1:0] l,
                           logic [VOICE_W-1:0] v);
            seq_event_t e;
            e.ev    = ev;
            e.pitch = p;
            e.loud  = l;
            e.voice = v;
            e.last  = 1'b0;
            burst.push_back(e);
        endfunction

        function void cut_song();
            if (playing)
                emit(EV_CUT, '0, '0, '0);
            playing  = 1'b0;
            sounding = 1'b0;
        endfunction

        // One update tick: voice check, gate release, then drain due events
        function void advance_song(logic [VOICE_W-1:0] cv);
            nsg_entry_t e;
            int         tail;
            if (!playing)
                return;
            if (cv != held_voice) begin
                cut_song();
                return;
            end
            if (sounding) begin
                to_release -= tick_step;
                if (to_release <= 0) begin
                    emit(EV_RELEASE, '0, '0, '0);
                    sounding = 1'b0;
                end
            end
            to_next -= tick_step;
            while (to_next <= 0 && burst.size() < MAX_RES) begin
                if (next_idx >= song_count) begin
                    cut_song();
                    return;
                end
                e = notes[song_addr(next_idx)];
                next_idx++;
                to_next += to_fix(int'(e.delay));
                if (e.pitch == REST_PITCH) begin
                    emit(EV_RELEASE, '0, '0, '0);
                    sounding = 1'b0;
                end
                else begin
                    tail = (int'(e.gate) * int'(e.delay)) >> GATE_SHIFT;
                    emit(EV_ON, e.pitch, e.loud, held_voice);
                    to_release = to_fix(int'(e.delay) - tail);
                    sounding   = 1'b1;
                end
            end
        endfunction

        // Note an accepted input transaction and queue the events it causes
        function void note_transaction(seq_txn_t t);
            nsg_entry_t e;
            burst.delete();
            case (t.act)
                ACT_LOAD: begin
                    e.pitch = t.pitch;
                    e.delay = t.delay;
                    e.loud  = t.loud;
                    e.gate  = t.gate;
                    notes[int'(t.addr) % NOTE_DEPTH]  = e;
                    loaded[int'(t.addr) % NOTE_DEPTH] = 1'b1;
                end
                ACT_START: begin
                    if (t.voice == '0 || t.len == '0)
                        emit(EV_REFUSED, '0, '0, '0);
                    else begin
                        cut_song();
                        song_base  = int'(t.first);
                        song_count = int'(t.len);
                        next_idx   = 0;
                        to_next    = 0;
                        to_release = 0;
                        tick_step  = int'(t.step_size);
                        held_voice = t.voice;
                        playing    = 1'b1;
                        sounding   = 1'b0;
                        emit(EV_TAKEN, '0, '0, '0);
                    end
                end
                ACT_STOP:
                    cut_song();
                default:
                    advance_song(t.cur_voice);
            endcase
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                expected_events.push_back(burst[i]);
        endfunction

        // Address of an unloaded entry the next tick would read, or -1
        function int missing_entry(logic [VOICE_W-1:0] cv);
            int t;
            int idx;
            int n;
            int a;
            if (!playing || cv != held_voice)
                return -1;
            n   = (sounding && to_release - tick_step <= 0) ? 1 : 0;
            t   = to_next - tick_step;
            idx = next_idx;
            while (t <= 0 && n < MAX_RES) begin
                if (idx >= song_count)
                    return -1;
                a = song_addr(idx);
                if (!loaded[a])
                    return a;
                t += to_fix(int'(notes[a].delay));
                idx++;
                n++;
            end
            return -1;
        endfunction

        function void check_event(seq_event_t got);
            seq_event_t want;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected event: ev %0d pitch %0d loud %0d voice %0d last %0d",
                             got.ev, got.pitch, got.loud, got.voice, got.last);
                return;
            end
            want = expected_events.pop_front();
            if (got.ev != want.ev || got.pitch != want.pitch || got.loud != want.loud ||
                got.voice != want.voice || got.last != want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"event mismatch: expected ev %0d pitch %0d loud %0d voice %0d",
                              " last %0d, got ev %0d pitch %0d loud %0d voice %0d last %0d"},
                             want.ev, want.pitch, want.loud, want.voice, want.last,
                             got.ev, got.pitch, got.loud, got.voice, got.last);
            end
        endfunction

    endclass

endpackage

>>> tb/tb_note_sequencer_with_gate_time.sv
module tb_note_sequencer_with_gate_time;

    import nsg_pkg::*;
    import nsg_tb_pkg::*;

    // Random items per phase; the result flood adds roughly seventy more
    localparam int PHASE_ITEMS  = 65;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // A tick can drain up to 64 events
    localparam int DRAIN_CYCLES = 300;
    localparam int FLOOD_LEN    = 66;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACT_W-1:0]     action;
    logic [7:0]           entry_addr;
    logic [PITCH_W-1:0]   pitch;
    logic [DELAY_W-1:0]   delay_ticks;
    logic [LOUD_W-1:0]    loudness;
    logic [GATE_W-1:0]    gate;
    logic [7:0]           song_first;
    logic [LEN_W-1:0]     song_length;
    logic [STEP_W-1:0]    step_size;
    logic [VOICE_W-1:0]   voice;
    logic [VOICE_W-1:0]   current_voice;
    logic                 out_valid;
    logic                 out_stall;
    logic [EV_W-1:0]      event_res;
    logic [PITCH_W-1:0]   note_pitch;
    logic [LOUD_W-1:0]    note_loudness;
    logic [VOICE_W-1:0]   note_voice;
    logic                 last;

    sequencer_scoreboard  seq_model;
    seq_event_t           got_event;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   items_sent;
    int                   cycles = 0;

    note_sequencer_with_gate_time dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .entry_addr    (entry_addr),
        .pitch         (pitch),
        .delay_ticks   (delay_ticks),
        .loudness      (loudness),
        .gate          (gate),
        .song_first    (song_first),
        .song_length   (song_length),
        .step_size     (step_size),
        .voice         (voice),
        .current_voice (current_voice),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .note_pitch    (note_pitch),
        .note_loudness (note_loudness),
        .note_voice    (note_voice),
        .last          (last)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver side: stall at the rate of the current phase, change only on the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check every result transaction against the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            got_event.ev    = nsg_event_t'(event_res);
            got_event.pitch = note_pitch;
            got_event.loud  = note_loudness;
            got_event.voice = note_voice;
            got_event.last  = last;
            seq_model.check_event(got_event);
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Fill every field at random; callers then set what the action needs, so unused
    // fields still toggle and must be ignored by the block
    function automatic seq_txn_t random_txn();
        seq_txn_t t;
        t.act       = nsg_action_t'($urandom_range(3));
        t.addr      = 8'($urandom_range(255));
        t.pitch     = PITCH_W'($urandom_range(127));
        t.delay     = DELAY_W'($urandom_range(65535, 1));
        t.loud      = LOUD_W'($urandom_range(127));
        t.gate      = GATE_W'($urandom_range(255));
        t.first     = 8'($urandom_range(255));
        t.len       = LEN_W'($urandom_range(256));
        t.step_size = STEP_W'($urandom_range(15360, 1));
        t.voice     = VOICE_W'($urandom_range(255));
        t.cur_voice = VOICE_W'($urandom_range(255));
        return t;
    endfunction

    function automatic nsg_entry_t make_note(int p, int d, int l, int g);
        nsg_entry_t e;
        e.pitch = PITCH_W'(p);
        e.delay = DELAY_W'(d);
        e.loud  = LOUD_W'(l);
        e.gate  = GATE_W'(g);
        return e;
    endfunction

    // Mostly short delays so songs advance; a few long ones stall a song
    function automatic nsg_entry_t random_note();
        int r;
        int d;
        int p;
        r = $urandom_range(19);
        if (r < 8)
            d = $urandom_range(4, 1);
        else if (r < 14)
            d = $urandom_range(40, 5);
        else if (r < 17)
            d = $urandom_range(1000, 41);
        else if (r < 19)
            d = $urandom_range(65535, 1001);
        else
            d = 65535;
        p = ($urandom_range(4) == 0) ? int'(REST_PITCH) : $urandom_range(126);
        return make_note(p, d, $urandom_range(127), $urandom_range(255));
    endfunction

    // Present one transaction and hold it until accepted. Enter and leave on a falling edge,
    // so valid gets exactly one assignment per time step.
    task automatic send(seq_txn_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= t.act;
        entry_addr    <= t.addr;
        pitch         <= t.pitch;
        delay_ticks   <= t.delay;
        loudness      <= t.loud;
        gate          <= t.gate;
        song_first    <= t.first;
        song_length   <= t.len;
        step_size     <= t.step_size;
        voice         <= t.voice;
        current_voice <= t.cur_voice;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        seq_model.note_transaction(t);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_note(int addr, nsg_entry_t e);
        seq_txn_t t;
        t       = random_txn();
        t.act   = ACT_LOAD;
        t.addr  = 8'(addr);
        t.pitch = e.pitch;
        t.delay = e.delay;
        t.loud  = e.loud;
        t.gate  = e.gate;
        send(t);
    endtask

    task automatic start_song(int first, int len, int stride, int v);
        seq_txn_t t;
        t           = random_txn();
        t.act       = ACT_START;
        t.first     = 8'(first);
        t.len       = LEN_W'(len);
        t.step_size = STEP_W'(stride);
        t.voice     = VOICE_W'(v);
        send(t);
    endtask

    task automatic stop_song();
        seq_txn_t t;
        t     = random_txn();
        t.act = ACT_STOP;
        send(t);
    endtask

    // Refused start: zero voice, zero length, or both
    task automatic refuse_start();
        case ($urandom_range(2))
            0: start_song($urandom_range(255), $urandom_range(256, 1), $urandom_range(15360, 1), 0);
            1: start_song($urandom_range(255), 0, $urandom_range(15360, 1), $urandom_range(255, 1));
            default: start_song($urandom_range(255), 0, $urandom_range(15360, 1), 0);
        endcase
    endtask

    // Load every entry the tick would read before it is written, then send the tick
    task automatic tick(logic [VOICE_W-1:0] cv);
        int       need;
        seq_txn_t t;
        need = seq_model.missing_entry(cv);
        while (need >= 0) begin
            load_note(need, random_note());
            need = seq_model.missing_entry(cv);
        end
        t           = random_txn();
        t.act       = ACT_TICK;
        t.cur_voice = cv;
        send(t);
    endtask

    // Drop valid and hold off until every expected event has arrived
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (seq_model.pending() != 0)
            @(negedge clk);
    endtask

    task automatic directed_checks();
        int k;
        // idle tick and idle stop give nothing
        tick(8'd0);
        stop_song();
        refuse_start();
        start_song(5, 3, 256, 0);
        start_song(5, 0, 256, 9);
        // song wrapping from the top of the memory: shortest nonzero delay, rest, extremes
        load_note(254, make_note(0, 1, 0, 0));
        load_note(255, make_note(int'(REST_PITCH), 2, 127, 255));
        load_note(0, make_note(126, 3, 127, 128));
        load_note(1, make_note(60, 65535, 1, 255));
        start_song(254, 4, 256, 255);
        for (k = 0; k < 4; k++)
            tick(8'd255);
        // zero-delay entry drained in the same tick; zero step stalls the song
        load_note(10, make_note(64, 0, 64, 0));
        load_note(11, make_note(1, 3, 100, 85));
        start_song(10, 2, 0, 1);
        tick(8'd1);
        tick(8'd1);
        stop_song();
        // largest step drains the whole song at once, then a voice change cuts it
        start_song(254, 4, 15360, 128);
        tick(8'd128);
        tick(8'd127);
        // full-length song wrapping around the memory
        start_song(200, 256, 512, 77);
        tick(8'd77);
        tick(8'd77);
        stop_song();
    endtask

    // Fill more zero-delay entries than one tick may drain, so the result limit
    // defers the rest to the next tick, which then runs off the end of the song
    task automatic result_flood();
        int                  base;
        int                  k;
        logic [VOICE_W-1:0]  v;
        nsg_entry_t          e;
        base = $urandom_range(255);
        v    = VOICE_W'($urandom_range(255, 1));
        for (k = 0; k < FLOOD_LEN; k++) begin
            e       = random_note();
            e.delay = '0;
            load_note((base + k) % NOTE_DEPTH, e);
        end
        start_song(base, FLOOD_LEN, 256, int'(v));
        tick(v);
        tick(v);
        tick(v);
    endtask

    task automatic play_random_song();
        int                  first;
        int                  len;
        int                  stride;
        int                  n_ticks;
        int                  k;
        logic [VOICE_W-1:0]  v;
        v     = VOICE_W'($urandom_range(255, 1));
        first = $urandom_range(255);
        case ($urandom_range(9))
            7, 8:    len = $urandom_range(40, 13);
            9:       len = 256;
            default: len = $urandom_range(12, 1);
        endcase
        case ($urandom_range(4))
            0:       stride = 256;
            1:       stride = $urandom_range(256, 16);
            2:       stride = $urandom_range(1024, 1);
            3:       stride = $urandom_range(15360, 1);
            default: stride = 15360;
        endcase
        // Half the songs get up to twelve entries loaded up front, the rest get entries just in time
        if ($urandom_range(1) == 0)
            for (k = 0; k < len && k < 12; k++)
                load_note((first + k) % NOTE_DEPTH, random_note());
        start_song(first, len, stride, int'(v));
        n_ticks = $urandom_range(24, 3);
        for (k = 0; k < n_ticks; k++) begin
            if (!seq_model.playing && $urandom_range(3) != 0)
                break;
            case ($urandom_range(19))
                0:       tick(VOICE_W'($urandom_range(255)));
                1:       load_note($urandom_range(255), random_note());
                2:       refuse_start();
                3:       stop_song();
                default: tick(v);
            endcase
        end
        if ($urandom_range(2) == 0)
            stop_song();
    endtask

    task automatic random_noise();
        case ($urandom_range(3))
            0:       refuse_start();
            1:       stop_song();
            2:       tick(VOICE_W'($urandom_range(255)));
            default: load_note($urandom_range(255), random_note());
        endcase
    endtask

    initial
    begin
        int phase;
        int phase_end;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_LOAD;
        entry_addr     = '0;
        pitch          = '0;
        delay_ticks    = '0;
        loudness       = '0;
        gate           = '0;
        song_first     = '0;
        song_length    = '0;
        step_size      = '0;
        voice          = '0;
        current_voice  = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 37;
        recv_stall_pct = 87;
        items_sent     = 0;
        seq_model      = new();

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_checks();
        // Hold the sender until the block has delivered everything
        wait_quiet();
        result_flood();

        // Sender idles lightly while the receiver stalls heavily, then swap, then run flat out
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 87;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 37;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(6) == 0)
                    random_noise();
                else
                    play_random_song();
            end
        end

        // Drain: wait for every expected event, then let the block settle
        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (seq_model.mismatches == 0 && seq_model.pending() == 0)
            $display("status: pass");
        else begin
            if (seq_model.pending() != 0)
                $display("%0d expected events never arrived", seq_model.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule
